>>> rtl/rrt_tree_extend_defines.svh
// Assertion helpers for the RTL of the tree extension block.
`ifndef RRT_TREE_EXTEND_DEFINES_SVH
`define RRT_TREE_EXTEND_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and constants of the RRT tree extension block.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int NUM_JOINTS = 6;
  localparam int STEP_W     = 15;
  localparam int CFG_ADDR_W = 5;

  localparam logic [STEP_W-1:0] STEP_RESET = 15'd41;
  localparam logic [STEP_W-1:0] TOL_RESET  = 15'd410;

  typedef enum logic [2:0] {
    REG_GOAL_1,
    REG_GOAL_2,
    REG_GOAL_3,
    REG_GOAL_4,
    REG_GOAL_5,
    REG_GOAL_6,
    REG_STEP,
    REG_TOL
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SQRT_S,
    ST_SQRT,
    ST_MAG,
    ST_DIV_S,
    ST_DIV,
    ST_STEP,
    ST_GOAL_SQ,
    ST_GOAL_SUM,
    ST_GOAL_CMP,
    ST_COMMIT,
    ST_FINISH
  } state_e;

endpackage

>>> rtl/rrt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_lane
// One joint lane: registered difference magnitude, sign and square.
// ----------------------------------------------------------------------------
module rrt_lane #(
  parameter int OPW = 16
) (
  input  logic                   clk_i,
  input  logic signed [OPW-1:0]  a_i,
  input  logic signed [OPW-1:0]  b_i,
  output logic [OPW:0]           mag_o,
  output logic                   neg_o,
  output logic [2*OPW+1:0]       sq_o
);

  logic signed [OPW:0] diff;
  logic [OPW:0]        mag;

  assign diff = (OPW+1)'(a_i) - (OPW+1)'(b_i);
  assign mag  = diff[OPW] ? (OPW+1)'(-diff) : (OPW+1)'(diff);

  always_ff @(posedge clk_i) begin
    mag_o <= mag;
    neg_o <= diff[OPW];
    sq_o  <= (2*OPW+2)'(mag) * (2*OPW+2)'(mag);
  end

endmodule

>>> rtl/rrt_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_isqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rrt_isqrt #(
  parameter int SW = 38
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SW-1:0]     rad_i,
  output logic [SW/2-1:0]   root_o,
  output logic              done_o
);

  localparam int RW  = SW / 2;
  localparam int CNW = $clog2(RW + 1);

  logic [SW-1:0]   rad_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [CNW-1:0]  cnt_q;
  logic            busy_q;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            take;

  assign rem_sh = {rem_q[RW-1:0], rad_q[SW-1:SW-2]};
  assign trial  = {root_q, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNW'(RW - 1)) begin
        busy_q <= 1'b0;
        done_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SW-3:0], 2'b00};
      rem_q  <= take ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RW-2:0], take};
    end
  end

  assign root_o = root_q;

endmodule

>>> rtl/rrt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrt_div #(
  parameter int NW = 32,
  parameter int DNW = 19
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DNW-1:0]  den_i,
  output logic [NW-1:0]   quo_o,
  output logic            done_o
);

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]   num_q;
  logic [DNW-1:0]  den_q;
  logic [DNW-1:0]  rem_q;
  logic [CNW-1:0]  cnt_q;
  logic            busy_q;
  logic [DNW:0]    rem_sh;
  logic [DNW:0]    rem_sub;
  logic            take;

  assign rem_sh  = {rem_q, num_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign take    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNW'(NW - 1)) begin
        busy_q <= 1'b0;
        done_o <= 1'b1;
      end
    end
  end

  // The dividend register shifts the quotient in from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], take};
      rem_q <= take ? rem_sub[DNW-1:0] : rem_sh[DNW-1:0];
    end
  end

  assign quo_o = num_q;

endmodule

>>> rtl/rrt_tree_extend.sv
`timescale 1ns / 1ps
// Restart items pass through the commit and finish states; refused extensions go straight to finish.
// In an extension, six joint lanes scan one stored node per cycle, then a bit-serial
// square root and six bit-serial dividers set the step toward the sample.
// One item is in work at a time; the next is taken while a result waits.
// Reset clears the tree, the goal flag and loads the register defaults.
// ----------------------------------------------------------------------------
// rrt_tree_extend
// Six-joint RRT tree extension with nearest-node search and goal check.
// ----------------------------------------------------------------------------
module rrt_tree_extend
  import rrt_pkg::*;
#(
  parameter int MAX_NODES   = 1024,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic signed [15:0]    angle_1_i,
  input  logic signed [15:0]    angle_2_i,
  input  logic signed [15:0]    angle_3_i,
  input  logic signed [15:0]    angle_4_i,
  input  logic signed [15:0]    angle_5_i,
  input  logic signed [15:0]    angle_6_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    new_angle_1_o,
  output logic signed [15:0]    new_angle_2_o,
  output logic signed [15:0]    new_angle_3_o,
  output logic signed [15:0]    new_angle_4_o,
  output logic signed [15:0]    new_angle_5_o,
  output logic signed [15:0]    new_angle_6_o,
  output logic [9:0]            parent_index_o,
  output logic [9:0]            node_index_o,
  output logic                  added_o,
  output logic                  goal_reached_o
);

  `include "rrt_tree_extend_defines.svh"

  localparam int AW  = ANGLE_WIDTH;
  localparam int OW  = (AW > 16) ? AW : 16;
  localparam int DW  = OW + 1;
  localparam int SW  = 2 * DW + 4;
  localparam int RW  = SW / 2;
  localparam int NW  = STEP_W + DW;
  localparam int PW  = NW + 2;
  localparam int IW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int ROW = NUM_JOINTS * AW;

  localparam logic signed [PW-1:0] SAT_HI = {{(PW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [AW-1:0] sat_f(input logic signed [PW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > SAT_HI) r = SAT_HI[AW-1:0];
    else if (v < SAT_LO) r = SAT_LO[AW-1:0];
    else r = v[AW-1:0];
    return r;
  endfunction

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [15:0]  goal_q [NUM_JOINTS];
  logic [STEP_W-1:0]   step_q, tol_q;
  logic                cfg_wr;
  cfg_reg_e            cfg_idx;

  // Tree state.
  logic [CW-1:0]       count_q;
  logic                goal_done_q;
  logic [ROW-1:0]      mem [MAX_NODES];
  logic [ROW-1:0]      rd_q;
  logic [ROW-1:0]      wr_row;

  // Item state.
  logic signed [15:0]  in_ang [NUM_JOINTS];
  logic signed [OW-1:0] sample_q [NUM_JOINTS];
  logic                restart_q;
  logic [CW-1:0]       scan_q;
  logic                v1_q, v2_q, v3_q;
  logic [IW-1:0]       idx1_q, idx2_q, idx3_q;
  logic [ROW-1:0]      row2_q, row3_q;
  logic [SW-1:0]       sum_q, best_q;
  logic [IW-1:0]       best_idx_q;
  logic [ROW-1:0]      best_row_q;
  logic                neg_hold_q [NUM_JOINTS];
  logic signed [AW-1:0] pose_q [NUM_JOINTS];
  logic [IW-1:0]       idx_q, parent_q;
  logic                added_q, reached_q;

  // Lanes and serial units.
  logic signed [OW-1:0] lane_a [NUM_JOINTS];
  logic signed [OW-1:0] lane_b [NUM_JOINTS];
  logic [DW-1:0]       mag [NUM_JOINTS];
  logic                neg [NUM_JOINTS];
  logic [2*DW-1:0]     sq [NUM_JOINTS];
  logic [SW-1:0]       sum_d;
  logic [RW-1:0]       root;
  logic                sqrt_done;
  logic [NW-1:0]       quo [NUM_JOINTS];
  logic                div_done [NUM_JOINTS];
  logic                div_all;

  // Output register.
  logic                out_valid_q;
  logic [15:0]         oang_q [NUM_JOINTS];
  logic [9:0]          opar_q, onode_q;
  logic                oadded_q, oreached_q;

  // Controls.
  logic                in_xfer, refuse, scan_issue, scan_done;
  logic                sqrt_start, div_start, commit, load_out;
  logic [31:0]         par_ext, node_ext;

  assign in_ang[0] = angle_1_i;
  assign in_ang[1] = angle_2_i;
  assign in_ang[2] = angle_3_i;
  assign in_ang[3] = angle_4_i;
  assign in_ang[4] = angle_5_i;
  assign in_ang[5] = angle_6_i;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign refuse     = (count_q == '0) || (count_q >= CW'(MAX_NODES)) || goal_done_q;
  assign scan_done  = (scan_q == count_q) && !v1_q && !v2_q && !v3_q;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_GOAL_1, REG_GOAL_2, REG_GOAL_3,
      REG_GOAL_4, REG_GOAL_5, REG_GOAL_6: prdata = {16'd0, goal_q[cfg_idx]};
      REG_STEP: prdata = {17'd0, step_q};
      REG_TOL:  prdata = {17'd0, tol_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_JOINTS; k++) goal_q[k] <= '0;
      step_q <= STEP_RESET;
      tol_q  <= TOL_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GOAL_1, REG_GOAL_2, REG_GOAL_3,
        REG_GOAL_4, REG_GOAL_5, REG_GOAL_6: goal_q[cfg_idx] <= pwdata[15:0];
        REG_STEP: step_q <= pwdata[STEP_W-1:0];
        REG_TOL:  tol_q  <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- state machine ----------------
  always_comb begin
    div_all = 1'b1;
    for (int k = 0; k < NUM_JOINTS; k++) div_all = div_all && div_done[k];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!func_i) state_d = ST_COMMIT;
          else if (refuse) state_d = ST_FINISH;
          else state_d = ST_SCAN;
        end
      end
      ST_SCAN:     if (scan_done) state_d = ST_SQRT_S;
      ST_SQRT_S:   state_d = ST_SQRT;
      ST_SQRT:     if (sqrt_done) state_d = ST_MAG;
      ST_MAG:      state_d = ST_DIV_S;
      ST_DIV_S:    state_d = ST_DIV;
      ST_DIV:      if (div_all) state_d = ST_STEP;
      ST_STEP:     state_d = ST_GOAL_SQ;
      ST_GOAL_SQ:  state_d = ST_GOAL_SUM;
      ST_GOAL_SUM: state_d = ST_GOAL_CMP;
      ST_GOAL_CMP: state_d = ST_COMMIT;
      ST_COMMIT:   state_d = ST_FINISH;
      ST_FINISH:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_issue = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_SCAN:   scan_issue = (scan_q != count_q);
      ST_SQRT_S: sqrt_start = 1'b1;
      ST_DIV_S:  div_start  = 1'b1;
      ST_COMMIT: commit     = 1'b1;
      ST_FINISH: load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // ---------------- lanes ----------------
  always_comb begin
    for (int k = 0; k < NUM_JOINTS; k++) begin
      case (state_q)
        ST_MAG: begin
          lane_a[k] = sample_q[k];
          lane_b[k] = OW'(signed'(best_row_q[k*AW +: AW]));
        end
        ST_GOAL_SQ: begin
          lane_a[k] = OW'(pose_q[k]);
          lane_b[k] = OW'(goal_q[k]);
        end
        default: begin
          lane_a[k] = OW'(signed'(rd_q[k*AW +: AW]));
          lane_b[k] = sample_q[k];
        end
      endcase
    end
  end

  for (genvar k = 0; k < NUM_JOINTS; k++) begin : g_lane
    rrt_lane #(.OPW(OW)) u_lane (
      .clk_i (clk_i),
      .a_i   (lane_a[k]),
      .b_i   (lane_b[k]),
      .mag_o (mag[k]),
      .neg_o (neg[k]),
      .sq_o  (sq[k])
    );

    rrt_div #(.NW(NW), .DNW(RW)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (NW'(step_q) * NW'(mag[k])),
      .den_i   (root),
      .quo_o   (quo[k]),
      .done_o  (div_done[k])
    );
  end

  // Merge stage: sum of the six lane squares.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NUM_JOINTS; k++) sum_d = sum_d + SW'(sq[k]);
  end

  rrt_isqrt #(.SW(SW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (best_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  // ---------------- node memory ----------------
  always_comb begin
    for (int k = 0; k < NUM_JOINTS; k++) wr_row[k*AW +: AW] = pose_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (commit) mem[idx_q] <= wr_row;
    rd_q <= mem[scan_q[IW-1:0]];
  end

  // ---------------- scan pipeline control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= scan_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      goal_done_q <= 1'b0;
    end else if (commit) begin
      count_q     <= restart_q ? CW'(1) : count_q + 1'b1;
      goal_done_q <= restart_q ? 1'b0 : reached_q;
    end
  end

  // ---------------- item datapath ----------------
  always_ff @(posedge clk_i) begin
    idx1_q <= scan_q[IW-1:0];
    idx2_q <= idx1_q;
    row2_q <= rd_q;
    idx3_q <= idx2_q;
    row3_q <= row2_q;
    sum_q  <= sum_d;
    if (scan_issue) scan_q <= scan_q + 1'b1;

    // The first node always wins; later ones only on a strictly smaller distance.
    if (v3_q && ((idx3_q == '0) || (sum_q < best_q))) begin
      best_q     <= sum_q;
      best_idx_q <= idx3_q;
      best_row_q <= row3_q;
    end

    if (in_xfer) begin
      restart_q <= !func_i;
      parent_q  <= '0;
      reached_q <= 1'b0;
      scan_q    <= '0;
      for (int k = 0; k < NUM_JOINTS; k++) sample_q[k] <= OW'(in_ang[k]);
      if (!func_i) begin
        idx_q   <= '0;
        added_q <= 1'b1;
        for (int k = 0; k < NUM_JOINTS; k++) pose_q[k] <= sat_f(PW'(in_ang[k]));
      end else if (refuse) begin
        idx_q   <= '0;
        added_q <= 1'b0;
        for (int k = 0; k < NUM_JOINTS; k++) pose_q[k] <= '0;
      end else begin
        idx_q   <= count_q[IW-1:0];
        added_q <= 1'b1;
      end
    end

    if (div_start) begin
      for (int k = 0; k < NUM_JOINTS; k++) neg_hold_q[k] <= neg[k];
    end

    if (state_q == ST_STEP) begin
      parent_q <= best_idx_q;
      for (int k = 0; k < NUM_JOINTS; k++) begin
        if (root == '0) begin
          pose_q[k] <= signed'(best_row_q[k*AW +: AW]);
        end else if (neg_hold_q[k]) begin
          pose_q[k] <= sat_f(PW'(signed'(best_row_q[k*AW +: AW]))
                             - signed'(PW'(quo[k])));
        end else begin
          pose_q[k] <= sat_f(PW'(signed'(best_row_q[k*AW +: AW]))
                             + signed'(PW'(quo[k])));
        end
      end
    end

    if (state_q == ST_GOAL_CMP) begin
      reached_q <= sum_q < SW'({{STEP_W{1'b0}}, tol_q} * {{STEP_W{1'b0}}, tol_q});
    end
  end

  // ---------------- output register ----------------
  assign par_ext  = 32'(parent_q);
  assign node_ext = 32'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (load_out) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int k = 0; k < NUM_JOINTS; k++) oang_q[k] <= 16'(OW'(pose_q[k]));
      opar_q     <= par_ext[9:0];
      onode_q    <= node_ext[9:0];
      oadded_q   <= added_q;
      oreached_q <= reached_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_angle_1_o  = oang_q[0];
  assign new_angle_2_o  = oang_q[1];
  assign new_angle_3_o  = oang_q[2];
  assign new_angle_4_o  = oang_q[3];
  assign new_angle_5_o  = oang_q[4];
  assign new_angle_6_o  = oang_q[5];
  assign parent_index_o = opar_q;
  assign node_index_o   = onode_q;
  assign added_o        = oadded_q;
  assign goal_reached_o = oreached_q;

  // ---------------- assertions ----------------
  `RRT_ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(MAX_NODES), "node count overflow")
  `RRT_ASSERT_IMP(a_goal_has_tree, goal_done_q, count_q != '0, "goal flag without a tree")
  `RRT_ASSERT_NXT(a_accept_busy, in_xfer, state_q != ST_IDLE, "accepted item left idle")
  `RRT_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN, scan_q <= count_q, "scan past node count")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the RRT tree extension block against a software tree kept in step
// with every accepted item: restarts, nearest-node extensions, refusals and
// goal detection, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import rrt_pkg::*;

  localparam int TREE_DEPTH = 1024;

  typedef struct {
    shortint ang [NUM_JOINTS];
    int      parent;
    int      node;
    bit      added;
    bit      reached;
  } node_result_t;

  // Software copy of the tree and the registers; predicts one result per item.
  class tree_model;
    shortint      tree [TREE_DEPTH][NUM_JOINTS];
    int           count;
    bit           done;
    shortint      goal [NUM_JOINTS];
    int           step;
    int           tol;
    node_result_t pending [$];
    int           errors;

    function new();
      count = 0;
      done = 0;
      foreach (goal[k]) goal[k] = 0;
      step = STEP_RESET;
      tol = TOL_RESET;
      errors = 0;
    endfunction

    function longint unsigned sq_dist(shortint a [NUM_JOINTS], shortint b [NUM_JOINTS]);
      longint unsigned acc;
      longint diff;
      acc = 0;
      for (int k = 0; k < NUM_JOINTS; k++) begin
        diff = longint'(a[k]) - longint'(b[k]);
        acc += longint'(diff * diff);
      end
      return acc;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    function void note_input(bit extend, shortint smp [NUM_JOINTS]);
      node_result_t     r;
      longint unsigned  best, d2, span, mag, delta;
      longint           diff, v;
      int               near_i;
      r.parent = 0;
      r.node = 0;
      r.added = 0;
      r.reached = 0;
      foreach (r.ang[k]) r.ang[k] = 0;
      if (!extend) begin
        foreach (smp[k]) tree[0][k] = smp[k];
        count = 1;
        done = 0;
        r.ang = smp;
        r.added = 1;
      end else if (count != 0 && count < TREE_DEPTH && !done) begin
        best = 0;
        near_i = 0;
        for (int j = 0; j < count; j++) begin
          d2 = sq_dist(tree[j], smp);
          if (j == 0 || d2 < best) begin
            best = d2;
            near_i = j;
          end
        end
        span = floor_sqrt(best);
        for (int k = 0; k < NUM_JOINTS; k++) begin
          if (span == 0) begin
            r.ang[k] = tree[near_i][k];
          end else begin
            diff = longint'(smp[k]) - longint'(tree[near_i][k]);
            mag = diff < 0 ? -diff : diff;
            delta = longint'(step) * mag / span;
            v = longint'(tree[near_i][k]) + (diff < 0 ? -longint'(delta) : longint'(delta));
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.ang[k] = shortint'(v);
          end
        end
        foreach (r.ang[k]) tree[count][k] = r.ang[k];
        r.parent = near_i;
        r.node = count;
        r.added = 1;
        count++;
        r.reached = sq_dist(r.ang, goal) < longint'(tol) * longint'(tol);
        if (r.reached) done = 1;
      end
      pending = {pending, r};
    endfunction

    function void check_result(node_result_t got);
      node_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      for (int k = 0; k < NUM_JOINTS; k++) begin
        if (got.ang[k] != exp_r.ang[k]) begin
          $error("new_angle_%0d: expected %0d, got %0d", k + 1, exp_r.ang[k], got.ang[k]);
          errors++;
        end
      end
      if (got.parent != exp_r.parent) begin
        $error("parent_index: expected %0d, got %0d", exp_r.parent, got.parent);
        errors++;
      end
      if (got.node != exp_r.node) begin
        $error("node_index: expected %0d, got %0d", exp_r.node, got.node);
        errors++;
      end
      if (got.added != exp_r.added) begin
        $error("added: expected %0d, got %0d", exp_r.added, got.added);
        errors++;
      end
      if (got.reached != exp_r.reached) begin
        $error("goal_reached: expected %0d, got %0d", exp_r.reached, got.reached);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  func_i;
  logic signed [15:0]    angle_i [NUM_JOINTS];
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic signed [15:0]    new_angle_o [NUM_JOINTS];
  logic [9:0]            parent_index_o;
  logic [9:0]            node_index_o;
  logic                  added_o;
  logic                  goal_reached_o;

  tree_model tree_sb;
  bit        idle_on;
  int        hold_cycles;

  rrt_tree_extend dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .angle_1_i      (angle_i[0]),
    .angle_2_i      (angle_i[1]),
    .angle_3_i      (angle_i[2]),
    .angle_4_i      (angle_i[3]),
    .angle_5_i      (angle_i[4]),
    .angle_6_i      (angle_i[5]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_angle_1_o  (new_angle_o[0]),
    .new_angle_2_o  (new_angle_o[1]),
    .new_angle_3_o  (new_angle_o[2]),
    .new_angle_4_o  (new_angle_o[3]),
    .new_angle_5_o  (new_angle_o[4]),
    .new_angle_6_o  (new_angle_o[5]),
    .parent_index_o (parent_index_o),
    .node_index_o   (node_index_o),
    .added_o        (added_o),
    .goal_reached_o (goal_reached_o)
  );

  always #6 clk_i = ~clk_i;

  // Monitors sample before the block's own updates of this edge land.
  always @(posedge clk_i) begin
    shortint smp [NUM_JOINTS];
    if (rst_ni && in_valid_i && in_ready_o) begin
      foreach (smp[k]) smp[k] = angle_i[k];
      tree_sb.note_input(func_i, smp);
    end
  end

  always @(posedge clk_i) begin
    node_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      foreach (got.ang[k]) got.ang[k] = new_angle_o[k];
      got.parent = parent_index_o;
      got.node = node_index_o;
      got.added = added_o;
      got.reached = goal_reached_o;
      tree_sb.check_result(got);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Leaves psel high so that a following write starts with its setup cycle.
  task automatic apb_write(cfg_reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_STEP) tree_sb.step = val[STEP_W-1:0];
    else if (idx == REG_TOL) tree_sb.tol = val[STEP_W-1:0];
    else tree_sb.goal[int'(idx)] = val[15:0];
  endtask

  task automatic write_regs(shortint g [NUM_JOINTS], int stp, int tl);
    for (int k = 0; k < NUM_JOINTS; k++) apb_write(cfg_reg_e'(k), 32'(g[k]));
    apb_write(REG_STEP, 32'(stp));
    apb_write(REG_TOL, 32'(tl));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets the block finish all work before registers change.
  task automatic drain();
    while (tree_sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic send(bit extend, shortint a [NUM_JOINTS]);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= extend;
    foreach (a[k]) angle_i[k] <= a[k];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic void fill(ref shortint a [NUM_JOINTS], input shortint v);
    foreach (a[k]) a[k] = v;
  endfunction

  function automatic void rnd_pose(ref shortint a [NUM_JOINTS]);
    foreach (a[k]) a[k] = shortint'($urandom);
  endfunction

  function automatic void near_pose(ref shortint a [NUM_JOINTS], input shortint c [NUM_JOINTS],
                                    input int spread);
    foreach (a[k]) a[k] = shortint'(int'(c[k]) + $urandom_range(0, 2 * spread) - spread);
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32767;
      2: return $urandom_range(0, 32767);
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  initial begin
    shortint a [NUM_JOINTS];
    shortint g [NUM_JOINTS];
    shortint base [NUM_JOINTS];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    func_i = 1'b0;
    foreach (angle_i[k]) angle_i[k] = '0;
    out_ready_i = 1'b0;
    idle_on = 1'b0;
    hold_cycles = 0;
    tree_sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extension with no tree, extreme poses, zero distance.
    fill(a, 16'sh1234);
    send(1'b1, a);
    fill(a, 32767);
    send(1'b0, a);
    send(1'b1, a);
    fill(a, -32768);
    send(1'b1, a);
    send(1'b0, a);
    fill(a, 32767);
    send(1'b1, a);
    in_valid_i <= 1'b0;
    drain();

    // Huge step toward a far mixed sample, then a goal hit and the refusal after it.
    fill(g, 100);
    write_regs(g, 32767, 0);
    fill(a, 0);
    send(1'b0, a);
    a = '{32767, -32768, 32767, -32768, 1, -1};
    send(1'b1, a);
    in_valid_i <= 1'b0;
    drain();
    write_regs(g, 32767, 32767);
    fill(a, 0);
    send(1'b0, a);
    fill(a, 200);
    send(1'b1, a);
    send(1'b1, a);
    send(1'b0, a);
    send(1'b1, a);

    // Receiver holds off while restarts keep coming, so the input backs up.
    hold_cycles = 2000;
    for (int i = 0; i < 8; i++) begin
      rnd_pose(a);
      send(1'b0, a);
    end
    in_valid_i <= 1'b0;
    drain();

    // Random part: mostly short well-formed trees grown near the goal.
    idle_on = 1'b1;
    for (int i = 0; i < 540; i++) begin
      if (i % 60 == 0) begin
        in_valid_i <= 1'b0;
        drain();
        if ($urandom_range(0, 3) == 0) begin
          foreach (g[k]) g[k] = $urandom_range(0, 1) ? 32767 : -32768;
        end else begin
          rnd_pose(g);
        end
        write_regs(g, pick_step(), $urandom_range(0, 4) == 0 ? 32767 : $urandom_range(0, 3000));
        near_pose(base, g, 4000);
      end
      if (i > 440) idle_on = 1'b0;
      if (i % 25 == 0 || $urandom_range(0, 40) == 0) begin
        if ($urandom_range(0, 2) == 0) rnd_pose(base);
        else near_pose(base, g, 3000);
        send(1'b0, base);
      end else begin
        case ($urandom_range(0, 4))
          0: rnd_pose(a);
          1: a = base;
          default: near_pose(a, g, 2000);
        endcase
        send(1'b1, a);
      end
    end
    in_valid_i <= 1'b0;

    while (tree_sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (tree_sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
